FILE: hdl/kdsup_pkg.sv
// ----------------------------------------------------------------------------
// kdsup_pkg
// Types shared by the keypoint duplicate suppression core and its cells.
// ----------------------------------------------------------------------------
package kdsup_pkg;

   localparam int unsigned RADIUS_W   = 6;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd7;

   // one input beat
   typedef struct packed {
      logic signed [15:0] in_x;
      logic signed [15:0] in_y;
      logic [31:0]        in_score;
      logic [15:0]        in_id;
      logic [2:0]         in_level;
      logic               in_last;
   } req_type;

   // one result beat
   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic [31:0]        out_score;
      logic [15:0]        out_id;
      logic [2:0]         out_level;
      logic               kept;
      logic               out_last;
   } rsp_type;

   // keypoint held at home in a cell
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        score;
      logic [15:0]        id;
      logic [2:0]         level;
      logic               occ;
      logic               supp;
   } home_type;

   // keypoint circulating round the ring
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        score;
      logic               valid;
   } travel_type;

   // per-cycle controls from the sequencer
   typedef struct packed {
      logic load;
      logic copy;
      logic cmp;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: hdl/keypoint_duplicate_suppression_core.sv
// ----------------------------------------------------------------------------
// keypoint_duplicate_suppression_core
// Loads a keypoint set and emits it in order with a kept flag per keypoint.
// ----------------------------------------------------------------------------
// Each accepted beat loads one keypoint into its own cell while one is free.
// On the beat marked last the core goes busy: the copy state puts every cell
// onto the ring, the compare state rotates the keypoints round the ring of
// cells so that every cell sees every other, then the n loaded keypoints leave
// one a cycle on rsp_strobe, each registered and shown in the cycle after its
// emit cycle. Register writes wait while busy, so a new radius only ever
// applies to a whole set. Results cannot be held off by the receiver; take each
// one on the cycle its strobe is high.
module keypoint_duplicate_suppression_core
   import kdsup_pkg::*;
#(
   parameter int unsigned SET_SLOTS = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req,
   output logic                rsp_strobe,
   output rsp_type             rsp,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [RADIUS_W-1:0] csr_data
);

   localparam int unsigned CNT_W = $clog2(SET_SLOTS + 1);
   localparam int unsigned CYC_W = $clog2(SET_SLOTS);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SET_SLOTS);
   localparam logic [CYC_W-1:0] CYC_END = CYC_W'(SET_SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_COPY, ST_CMP, ST_EMIT} state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff, emit_ff;
   logic [CYC_W-1:0]    cyc_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic                strobe_ff;
   rsp_type             rsp_ff;
   logic                accept;

   cell_ctl_type ctl   [SET_SLOTS];
   travel_type   trav  [SET_SLOTS];
   home_type     home  [SET_SLOTS];
   home_type     hnext [SET_SLOTS];

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;

   // radius register
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   // the ring of cells
   for (genvar i = 0; i < SET_SLOTS; i++) begin : g_cell
      always_comb begin
         ctl[i].load  = accept && (count_ff == CNT_W'(i));
         ctl[i].copy  = (state_ff == ST_COPY);
         ctl[i].cmp   = (state_ff == ST_CMP);
         ctl[i].shift = (state_ff == ST_EMIT);
      end
      if (i == SET_SLOTS - 1) begin : g_top
         assign hnext[i] = '0;
      end else begin : g_mid
         assign hnext[i] = home[i+1];
      end
      kdsup_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl[i]),
         .req        (req),
         .radius     (radius_ff),
         .travel_in  (trav[(i + SET_SLOTS - 1) % SET_SLOTS]),
         .travel_out (trav[i]),
         .home_in    (hnext[i]),
         .home_out   (home[i])
      );
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         emit_ff   <= '0;
         cyc_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (count_ff != CNT_MAX) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (req.in_last) begin
                     state_ff <= ST_COPY;
                  end
               end
            end
            ST_COPY: begin
               cyc_ff   <= '0;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               cyc_ff <= cyc_ff + 1'b1;
               if (cyc_ff == CYC_END) begin
                  emit_ff  <= '0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               strobe_ff        <= 1'b1;
               rsp_ff.out_x     <= home[0].x;
               rsp_ff.out_y     <= home[0].y;
               rsp_ff.out_score <= home[0].score;
               rsp_ff.out_id    <= home[0].id;
               rsp_ff.out_level <= home[0].level;
               rsp_ff.kept      <= !home[0].x[15] && !home[0].y[15] && !home[0].supp;
               rsp_ff.out_last  <= (emit_ff == count_ff - 1'b1);
               emit_ff          <= emit_ff + 1'b1;
               if (emit_ff == count_ff - 1'b1) begin
                  count_ff <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

FILE: hdl/kdsup_cell.sv
// ----------------------------------------------------------------------------
// kdsup_cell
// One ring cell: holds a home keypoint, checks the passing keypoint against
// its window and hands the passing keypoint to the next cell.
// ----------------------------------------------------------------------------
module kdsup_cell
   import kdsup_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  req_type             req,
   input  logic [RADIUS_W-1:0] radius,
   input  travel_type          travel_in,
   output travel_type          travel_out,
   input  home_type            home_in,
   output home_type            home_out
);

   home_type   home_ff, home_in_c;
   travel_type travel_ff;

   logic signed [12:0] fx, fy, xlo_p, xhi_p, ylo_p, yhi_p;
   logic signed [16:0] xlo, xhi, ylo, yhi, tx, ty;
   logic               hit;

   // window bounds in 1/16 pixel
   always_comb begin
      fx    = $signed({2'b00, home_ff.x[14:4]});
      fy    = $signed({2'b00, home_ff.y[14:4]});
      xlo_p = fx - $signed({7'd0, radius});
      xhi_p = fx + $signed({7'd0, radius});
      ylo_p = fy - $signed({7'd0, radius});
      yhi_p = fy + $signed({7'd0, radius});
      xlo   = {xlo_p, 4'b0000};
      xhi   = {xhi_p, 4'b0000};
      ylo   = {ylo_p, 4'b0000};
      yhi   = {yhi_p, 4'b0000};
      tx    = {travel_ff.x[15], travel_ff.x};
      ty    = {travel_ff.y[15], travel_ff.y};
      hit   = travel_ff.valid && (ty >= ylo) && (ty <= yhi)
              && (tx > xlo) && (tx < xhi) && (home_ff.score < travel_ff.score);
   end

   // next home contents
   always_comb begin
      home_in_c = home_ff;
      if (ctl.load) begin
         home_in_c.x     = req.in_x;
         home_in_c.y     = req.in_y;
         home_in_c.score = req.in_score;
         home_in_c.id    = req.in_id;
         home_in_c.level = req.in_level;
         home_in_c.occ   = 1'b1;
         home_in_c.supp  = 1'b0;
      end else if (ctl.shift) begin
         home_in_c = home_in;
      end else if (ctl.cmp && hit) begin
         home_in_c.supp = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff <= '0;
      end else begin
         home_ff <= home_in_c;
      end
   end

   // travelling keypoint
   always_ff @(posedge clock) begin
      if (reset) begin
         travel_ff.valid <= 1'b0;
      end else if (ctl.copy) begin
         travel_ff.x     <= home_ff.x;
         travel_ff.y     <= home_ff.y;
         travel_ff.score <= home_ff.score;
         travel_ff.valid <= home_ff.occ && !home_ff.x[15] && !home_ff.y[15];
      end else if (ctl.cmp) begin
         travel_ff <= travel_in;
      end
   end

   assign travel_out = travel_ff;
   assign home_out   = home_ff;

endmodule

FILE: hdl/kdsup_checker.sv
// ----------------------------------------------------------------------------
// kdsup_checker
// Port-level checks on the keypoint duplicate suppression core.
// ----------------------------------------------------------------------------
module kdsup_checker
   import kdsup_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_strobe,
   input rsp_type rsp
);

   // a set leaves as one unbroken run of beats
   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp.out_last |=> rsp_strobe)
      else $error("result run broken before last beat");

   // nothing follows the last beat directly
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.out_last |=> !rsp_strobe)
      else $error("result beat after last beat");

   // a last beat in sends the core busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req.in_last |=> busy && !rsp_strobe)
      else $error("core not busy after last input beat");

   // results only leave while busy or on the cycle it drops
   a_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy || rsp.out_last)
      else $error("result beat while idle");

endmodule

bind keypoint_duplicate_suppression_core kdsup_checker u_kdsup_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

FILE: tb/sv/kdsup_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kdsup_scoreboard
// Watches the load, result and register channels of the suppression core,
// rebuilds each keypoint set, predicts the kept flags and compares each result.
// ----------------------------------------------------------------------------
module kdsup_scoreboard
   import kdsup_pkg::*;
#(
   parameter int unsigned SET_SLOTS = 64
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  req_type             req,
   input  logic                rsp_strobe,
   input  rsp_type             rsp,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [RADIUS_W-1:0] csr_data,
   output int                  fail_count,
   output int                  pending_count
);

   // keypoints of the set being loaded
   req_type             set_q[$];
   rsp_type             result_q[$];
   logic [RADIUS_W-1:0] radius;

   function automatic logic valid_point(req_type p);
      return p.in_x >= 0 && p.in_y >= 0;
   endfunction

   // expected result beats for a closed set
   task automatic emit_set();
      int     r, fx, fy, n;
      logic   keep;
      rsp_type o;
      r = int'(radius);
      n = set_q.size();
      for (int k = 0; k < n; k++) begin
         keep = valid_point(set_q[k]);
         fx = int'(set_q[k].in_x) >>> 4;
         fy = int'(set_q[k].in_y) >>> 4;
         if (keep) begin
            for (int j = 0; j < n; j++) begin
               if (valid_point(set_q[j])
                   && int'(set_q[j].in_y) >= (fy - r) * 16
                   && int'(set_q[j].in_y) <= (fy + r) * 16
                   && int'(set_q[j].in_x) >  (fx - r) * 16
                   && int'(set_q[j].in_x) <  (fx + r) * 16
                   && set_q[k].in_score < set_q[j].in_score)
                  keep = 1'b0;
            end
         end
         o.out_x     = set_q[k].in_x;
         o.out_y     = set_q[k].in_y;
         o.out_score = set_q[k].in_score;
         o.out_id    = set_q[k].in_id;
         o.out_level = set_q[k].in_level;
         o.kept      = keep;
         o.out_last  = (k == n - 1);
         result_q = {result_q, o};
      end
      set_q.delete();
   endtask

   task automatic report(string what, rsp_type got, rsp_type want);
      fail_count++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_q.delete();
         result_q.delete();
         radius        = RADIUS_RESET;
         fail_count    = 0;
         pending_count = 0;
      end else begin
         // register beat; a write on the last load beat counts for that set
         if (csr_valid && csr_ready) radius = csr_data;
         // result beat
         if (rsp_strobe) begin
            if (result_q.size() == 0) begin
               report("unexpected beat", rsp, '0);
            end else begin
               if (rsp.out_x != result_q[0].out_x) report("x", rsp, result_q[0]);
               if (rsp.out_y != result_q[0].out_y) report("y", rsp, result_q[0]);
               if (rsp.out_score != result_q[0].out_score)
                  report("score", rsp, result_q[0]);
               if (rsp.out_id != result_q[0].out_id) report("id", rsp, result_q[0]);
               if (rsp.out_level != result_q[0].out_level)
                  report("level", rsp, result_q[0]);
               if (rsp.kept != result_q[0].kept) report("kept", rsp, result_q[0]);
               if (rsp.out_last != result_q[0].out_last)
                  report("last", rsp, result_q[0]);
               void'(result_q.pop_front());
            end
         end
         // load beat; full store discards the keypoint
         if (start && !busy) begin
            if (set_q.size() < SET_SLOTS) set_q = {set_q, req};
            if (req.in_last) emit_set();
         end
         pending_count = result_q.size();
      end
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives keypoint sets and window radii into the suppression core; the
// scoreboard beside it predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
   import kdsup_pkg::*;

   localparam int unsigned SET_SLOTS   = 64;
   localparam int          STALL_LIMIT = 5000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   req_type             req = '0;
   logic                rsp_strobe;
   rsp_type             rsp;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [RADIUS_W-1:0] csr_data = '0;
   int                  fail_count;
   int                  pending_count;
   int                  idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   keypoint_duplicate_suppression_core #(.SET_SLOTS(SET_SLOTS)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   kdsup_scoreboard #(.SET_SLOTS(SET_SLOTS)) chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // watchdog on cycles with no beat
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // start may stay high after a beat that is followed with no gap
   task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic [31:0] score, logic last);
      int gap;
      start        <= 1'b1;
      req.in_x     <= x;
      req.in_y     <= y;
      req.in_score <= score;
      req.in_id    <= 16'($urandom);
      req.in_level <= 3'($urandom);
      req.in_last  <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until the set has drained, then let the core settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radius(logic [RADIUS_W-1:0] r);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // random coordinate: mostly a small cluster, sometimes anywhere
   function automatic logic signed [15:0] coord();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 400));
   endfunction

   task automatic random_set(int n);
      for (int i = 0; i < n; i++)
         send_point(coord(), coord(),
                    ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 3)) : $urandom,
                    i == n - 1);
   endtask

   initial begin
      int sent;
      int n;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, edges of window, at reset radius
      send_point(16'sh7fff, 16'sh7fff, 32'hffffffff, 1'b0);
      send_point(-16'sd1, 16'sd100, 32'hffffffff, 1'b0);
      send_point(16'sd100, -16'sd32768, 32'hffffffff, 1'b0);
      send_point(16'sd100, 16'sd100, 32'd10, 1'b0);
      send_point(16'sd100, 16'sd100, 32'd10, 1'b0);
      send_point(16'sd100 + 16'sd112, 16'sd100, 32'd20, 1'b0);
      send_point(16'sd96 + 16'sd112, 16'sd100, 32'd5, 1'b0);
      send_point(16'sd100, 16'sd96 + 16'sd112, 32'd30, 1'b0);
      send_point(16'sd0, 16'sd0, 32'd0, 1'b1);
      // single keypoint set
      send_point(16'sd0, 16'sd0, 32'd0, 1'b1);
      // radius zero then maximum
      write_radius(6'd0);
      random_set(6);
      write_radius(6'd63);
      random_set(6);
      // radius change in the middle of a set
      send_point(16'sd50, 16'sd50, 32'd1, 1'b0);
      start     <= 1'b0;
      csr_valid <= 1'b1;
      csr_data  <= 6'd2;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      send_point(16'sd90, 16'sd50, 32'd9, 1'b1);

      // full store plus discarded keypoints, one carrying last
      random_set(SET_SLOTS + 3);
      drain();
      sent = 0;
      while (sent < 170) begin
         if ($urandom_range(0, 5) == 0) write_radius(6'($urandom));
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 66) : $urandom_range(1, 8);
         random_set(n);
         sent += n;
      end

      drain();
      repeat (SET_SLOTS + 10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: keypoint_duplicate_suppression_core.f
hdl/kdsup_pkg.sv
hdl/kdsup_cell.sv
hdl/keypoint_duplicate_suppression_core.sv
hdl/kdsup_checker.sv
tb/sv/kdsup_checker.sv
tb/sv/tb.sv
